[rtl/core/lfpd_pkg.sv]
package lfpd_pkg;

  // fixed field widths
  localparam int SPEED_BITS   = 12;
  localparam int DEV_BITS     = 8;
  localparam int MAG_BITS     = 5;
  localparam int GAIN_BITS    = 16;
  localparam int TIMEOUT_BITS = 16;
  localparam int INTEG_BITS   = 16;
  localparam int MS_BITS      = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 16;

  // product widths
  localparam int PROD_P_BITS = GAIN_BITS + MAG_BITS;
  localparam int PROD_I_BITS = GAIN_BITS + INTEG_BITS;
  localparam int DIFF_BITS   = MAG_BITS + 1;
  localparam int PROD_D_BITS = GAIN_BITS + 1 + DIFF_BITS - 1;

  // thresholds
  localparam int LINE_LIMIT     = 17;
  localparam int INTEGRAL_CLEAR = 6;
  localparam int DERIV_CLEAR    = 1;
  localparam int SLOW_LIMIT     = 14;
  localparam int HIGH_MAX       = 1500;
  localparam int MID_MAX        = 1000;

  // register reset values
  localparam logic [SPEED_BITS-1:0]   MAX_SPEED_RST = SPEED_BITS'(2000);
  localparam logic [SPEED_BITS-1:0]   MIN_SPEED_RST = SPEED_BITS'(500);
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST   = TIMEOUT_BITS'(1000);
  localparam logic [GAIN_BITS-1:0]    GAIN_P_RST    = GAIN_BITS'(256);
  localparam logic [GAIN_BITS-1:0]    GAIN_I_RST    = '0;
  localparam logic [GAIN_BITS-1:0]    GAIN_D_RST    = '0;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_SPEED = 3'd0,
    CFG_MIN_SPEED = 3'd1,
    CFG_TIMEOUT   = 3'd2,
    CFG_GAIN_P    = 3'd3,
    CFG_GAIN_I    = 3'd4,
    CFG_GAIN_D    = 3'd5
  } lfpd_cfg_e;

  typedef enum logic {
    OP_READING = 1'b0,
    OP_TICK    = 1'b1
  } lfpd_op_e;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_ON_LINE = 2'd1,
    KIND_OFF     = 2'd2
  } lfpd_kind_e;

  typedef struct packed {
    logic                       operation;
    logic signed [DEV_BITS-1:0] deviation;
  } lfpd_in_t;

  typedef struct packed {
    logic [SPEED_BITS-1:0] left_speed;
    logic [SPEED_BITS-1:0] right_speed;
    logic                  line_lost_stop;
  } lfpd_out_t;

  // classified item held in the queue
  typedef struct packed {
    lfpd_kind_e          kind;
    logic                neg;
    logic                pos;
    logic [MAG_BITS-1:0] mag;
  } lfpd_entry_t;

  // pid stage to drive stage
  typedef struct packed {
    logic                          stop;
    logic                          neg;
    logic                          pos;
    logic                          slow;
    logic [PROD_P_BITS-1:0]        prod_p;
    logic [PROD_I_BITS-1:0]        prod_i;
    logic signed [PROD_D_BITS-1:0] prod_d;
  } lfpd_stage_t;

endpackage

[rtl/core/lfpd_front.sv]
module lfpd_front import lfpd_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lfpd_in_t    in_item_i,
  input  logic        full_i,
  output logic        push_o,
  output lfpd_entry_t entry_o
);

  logic [DEV_BITS-1:0] mag_full;

  always_comb begin
    mag_full = in_item_i.deviation[DEV_BITS-1] ? DEV_BITS'(-in_item_i.deviation)
                                               : DEV_BITS'(in_item_i.deviation);
    entry_o.neg = in_item_i.deviation[DEV_BITS-1];
    entry_o.pos = !in_item_i.deviation[DEV_BITS-1] && (in_item_i.deviation != '0);
    entry_o.mag = mag_full[MAG_BITS-1:0];
    if (in_item_i.operation == OP_TICK) begin
      entry_o.kind = KIND_TICK;
    end else if (32'(mag_full) < LINE_LIMIT) begin
      entry_o.kind = KIND_ON_LINE;
    end else begin
      entry_o.kind = KIND_OFF;
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

[rtl/core/lfpd_fifo.sv]
module lfpd_fifo import lfpd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  lfpd_entry_t entry_i,
  output logic        full_o,
  output logic        valid_o,
  output lfpd_entry_t entry_o,
  input  logic        pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lfpd_entry_t        mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_pop;

  assign do_pop  = pop_i && valid_o;
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

[rtl/core/lfpd_pid.sv]
module lfpd_pid import lfpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  lfpd_entry_t             q_entry_i,
  output logic                    q_ready_o,
  input  logic [GAIN_BITS-1:0]    gain_p_i,
  input  logic [GAIN_BITS-1:0]    gain_i_i,
  input  logic [GAIN_BITS-1:0]    gain_d_i,
  input  logic [TIMEOUT_BITS-1:0] timeout_i,
  output logic                    st_valid_o,
  output lfpd_stage_t             st_o,
  input  logic                    st_ready_i
);

  logic [INTEG_BITS-1:0]       integ_q, integ_d;
  logic [MAG_BITS-1:0]         prev_q;
  logic                        flag_q;
  logic [MS_BITS-1:0]          ms_q, ms_base;
  logic                        st_valid_q;
  lfpd_stage_t                 st_q, st_d;
  logic                        advance, pop;
  logic [INTEG_BITS:0]         integ_sum;
  logic [INTEG_BITS-1:0]       integ_sat;
  logic signed [DIFF_BITS-1:0] diff;
  logic                        stop_hit;

  assign advance    = !st_valid_q || st_ready_i;
  assign pop        = q_valid_i && advance;
  assign q_ready_o  = advance;
  assign st_valid_o = st_valid_q;
  assign st_o       = st_q;

  always_comb begin
    integ_sum = {1'b0, integ_q} + (INTEG_BITS + 1)'(q_entry_i.mag);
    integ_sat = integ_sum[INTEG_BITS] ? '1 : integ_sum[INTEG_BITS-1:0];
    integ_d   = (32'(q_entry_i.mag) <= INTEGRAL_CLEAR) ? '0 : integ_sat;
    diff      = $signed({1'b0, q_entry_i.mag}) - $signed({1'b0, prev_q});
    if (32'(q_entry_i.mag) <= DERIV_CLEAR) begin
      diff = '0;
    end
    // first off-line reading restarts the millisecond count
    ms_base  = flag_q ? ms_q : '0;
    stop_hit = ms_base > MS_BITS'(timeout_i);

    st_d.stop   = (q_entry_i.kind == KIND_OFF);
    st_d.neg    = q_entry_i.neg;
    st_d.pos    = q_entry_i.pos;
    st_d.slow   = 32'(q_entry_i.mag) >= SLOW_LIMIT;
    st_d.prod_p = PROD_P_BITS'(gain_p_i) * PROD_P_BITS'(q_entry_i.mag);
    st_d.prod_i = PROD_I_BITS'(gain_i_i) * PROD_I_BITS'(integ_d);
    st_d.prod_d = $signed(PROD_D_BITS'({1'b0, gain_d_i})) * PROD_D_BITS'(diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_q     <= '0;
      flag_q     <= 1'b0;
      ms_q       <= '0;
      st_valid_q <= 1'b0;
    end else if (pop) begin
      case (q_entry_i.kind)
        KIND_TICK: begin
          if (flag_q && ms_q != '1) begin
            ms_q <= ms_q + 1'b1;
          end
          st_valid_q <= 1'b0;
        end
        KIND_OFF: begin
          flag_q     <= 1'b1;
          ms_q       <= ms_base;
          st_valid_q <= stop_hit;
        end
        KIND_ON_LINE: begin
          flag_q     <= 1'b0;
          ms_q       <= '0;
          integ_q    <= integ_d;
          prev_q     <= q_entry_i.mag;
          st_valid_q <= 1'b1;
        end
        default: begin
          st_valid_q <= 1'b0;
        end
      endcase
    end else if (advance) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      st_q <= st_d;
    end
  end

endmodule

[rtl/core/lfpd_drive.sv]
module lfpd_drive import lfpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  st_valid_i,
  input  lfpd_stage_t           st_i,
  output logic                  st_ready_o,
  input  logic [SPEED_BITS-1:0] max_speed_i,
  input  logic [SPEED_BITS-1:0] min_speed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lfpd_out_t             out_item_o
);

  localparam int SUM_W = PROD_I_BITS + 2;
  localparam int CUT_W = SUM_W - 9;
  localparam int V_W   = CUT_W + 3;

  logic                    out_valid_q;
  lfpd_out_t               out_q, out_d;
  logic                    load;
  logic signed [SUM_W-1:0] sum, sum_abs;
  logic [CUT_W-1:0]        cut;
  logic signed [V_W-1:0]   max2, cut2, slow2, left2, right2;

  // twice the speed in, clamped and halved out
  function automatic logic [SPEED_BITS-1:0] clamp_half(
    input logic signed [V_W-1:0] v2,
    input logic signed [V_W-1:0] lim2,
    input logic [SPEED_BITS-1:0] lim
  );
    logic [SPEED_BITS-1:0] res;
    if (v2 <= 0) begin
      res = '0;
    end else if (v2 >= lim2) begin
      res = lim;
    end else begin
      res = v2[SPEED_BITS:1];
    end
    return res;
  endfunction

  assign load        = !out_valid_q || out_ready_i;
  assign st_ready_o  = load;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    sum     = $signed(SUM_W'(st_i.prod_p)) + $signed(SUM_W'(st_i.prod_i))
            + SUM_W'(st_i.prod_d);
    sum_abs = sum[SUM_W-1] ? -sum : sum;
    cut     = sum_abs[SUM_W-2:8];
    max2    = $signed(V_W'({max_speed_i, 1'b0}));
    cut2    = $signed(V_W'({cut, 1'b0}));
    slow2   = '0;
    if (st_i.slow) begin
      if (32'(max_speed_i) >= HIGH_MAX) begin
        slow2 = $signed(V_W'(min_speed_i)) + $signed(V_W'({min_speed_i, 1'b0}));
      end else if (32'(max_speed_i) >= MID_MAX) begin
        slow2 = $signed(V_W'({min_speed_i, 1'b0}));
      end
    end
    left2  = max2 - (st_i.pos ? cut2 : '0) - slow2;
    right2 = max2 - (st_i.neg ? cut2 : '0) - slow2;

    if (st_i.stop) begin
      out_d.left_speed     = '0;
      out_d.right_speed    = '0;
      out_d.line_lost_stop = 1'b1;
    end else begin
      out_d.left_speed     = clamp_half(left2, max2, max_speed_i);
      out_d.right_speed    = clamp_half(right2, max2, max_speed_i);
      out_d.line_lost_stop = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= st_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && st_valid_i) begin
      out_q <= out_d;
    end
  end

endmodule

[rtl/core/line_follow_pid_drive_core.sv]
// path: an accepted item passes through the queue and the pid stage register into the output register
// throughput: one item per cycle while the output is not held off, set by the pid stage whose state loop
//   and gain multiplies are computed from the queue head; the queue lets intake run ahead of a stalled output
// reset: asynchronous active low; registers return to their defaults, pid and
//   off-line state clear, queue and output empty; no clearing pass
module line_follow_pid_drive_core import lfpd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // guide readings and ticks
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  lfpd_in_t                in_item_i,
  // wheel speeds
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output lfpd_out_t               out_item_o,
  // register writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DAT_BITS-1:0] cfg_data_i
);

  // configuration registers
  logic [SPEED_BITS-1:0]   max_speed_q, min_speed_q;
  logic [TIMEOUT_BITS-1:0] timeout_q;
  logic [GAIN_BITS-1:0]    gain_p_q, gain_i_q, gain_d_q;

  // front to queue
  logic        q_full, q_push;
  lfpd_entry_t q_wr_entry;
  // queue to pid stage
  logic        q_valid, q_pop;
  lfpd_entry_t q_rd_entry;
  // pid stage to drive stage
  logic        st_valid, st_ready;
  lfpd_stage_t st;

  // the user must send writes only while idle (the block does not enforce this); they are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MAX_SPEED_RST;
      min_speed_q <= MIN_SPEED_RST;
      timeout_q   <= TIMEOUT_RST;
      gain_p_q    <= GAIN_P_RST;
      gain_i_q    <= GAIN_I_RST;
      gain_d_q    <= GAIN_D_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_SPEED: max_speed_q <= cfg_data_i[SPEED_BITS-1:0];
        CFG_MIN_SPEED: min_speed_q <= cfg_data_i[SPEED_BITS-1:0];
        CFG_TIMEOUT:   timeout_q   <= cfg_data_i[TIMEOUT_BITS-1:0];
        CFG_GAIN_P:    gain_p_q    <= cfg_data_i[GAIN_BITS-1:0];
        CFG_GAIN_I:    gain_i_q    <= cfg_data_i[GAIN_BITS-1:0];
        CFG_GAIN_D:    gain_d_q    <= cfg_data_i[GAIN_BITS-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // front: split ticks, on-line and off-line readings, fold deviation to magnitude
  lfpd_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (q_wr_entry)
  );

  // short queue decouples intake from the pid and drive stages
  lfpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_rd_entry),
    .pop_i   (q_pop)
  );

  // pid state, off-line timer and registered gain products
  lfpd_pid u_pid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_rd_entry),
    .q_ready_o  (q_pop),
    .gain_p_i   (gain_p_q),
    .gain_i_i   (gain_i_q),
    .gain_d_i   (gain_d_q),
    .timeout_i  (timeout_q),
    .st_valid_o (st_valid),
    .st_o       (st),
    .st_ready_i (st_ready)
  );

  // sum, steering cut, slowdown and clamp into the output register
  lfpd_drive u_drive (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_valid_i  (st_valid),
    .st_i        (st),
    .st_ready_o  (st_ready),
    .max_speed_i (max_speed_q),
    .min_speed_i (min_speed_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // a stop result carries zero speeds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.line_lost_stop |->
      out_item_o.left_speed == '0 && out_item_o.right_speed == '0)
    else $error("stop item with nonzero speed");

  // speeds never pass the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_item_o.left_speed <= max_speed_q && out_item_o.right_speed <= max_speed_q)
    else $error("speed above max_speed");

  // a full queue always has something to hand on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue full and empty at once");

endmodule

[tb/sv/line_follow_pid_drive_core_tb.sv]
module line_follow_pid_drive_core_tb;
  import lfpd_pkg::*;

  // clock and run limits
  localparam int HALF_PERIOD   = 5;
  localparam int SETTLE_CYCLES = 8;     // margin for the pid and output registers plus the intake queue
  localparam int STUCK_LIMIT   = 2000;  // cycles with no handshake on any channel
  localparam int MAX_REPORTS   = 10;
  localparam int SOAK_ITEMS    = 144;   // full-scale readings that build up the integral
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 112;
  localparam int IN_BITS       = $bits(lfpd_in_t);
  localparam longint INTEG_MAX = (longint'(1) << INTEG_BITS) - 1;

  // register indexes past the last real register, writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

  // how a phase picks its register values
  localparam int STYLE_ONES   = 0;
  localparam int STYLE_ZEROS  = 1;
  localparam int STYLE_RANDOM = 2;

  typedef enum int {PICK_ON_LINE, PICK_OFF_LINE, PICK_TICK, PICK_NOISE} pick_e;

  // one row of the directed walk: either a register write or an item,
  // optionally with the result typed in by hand
  typedef struct packed {
    logic                    is_cfg;
    lfpd_in_t                item;
    logic [CFG_IDX_BITS-1:0] reg_index;
    logic [CFG_DAT_BITS-1:0] reg_data;
    logic                    pinned;
    lfpd_out_t               pinned_res;
  } plan_row_t;

  typedef struct {
    bit        on;
    lfpd_out_t res;
  } pin_t;

  localparam int PLAN_ROWS = 42;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // stray register indexes
    '{1'b1, '0, CFG_SPARE_A, 16'hFFFF, 1'b0, '0},
    '{1'b1, '0, CFG_SPARE_B, 16'hFFFF, 1'b0, '0},
    // reset settings: max 2000, min 500, unit proportional gain
    '{1'b0, '{OP_READING, 8'sd0},   '0, '0, 1'b1, '{12'd2000, 12'd2000, 1'b0}},
    '{1'b0, '{OP_READING, 8'sd5},   '0, '0, 1'b1, '{12'd1995, 12'd2000, 1'b0}},
    '{1'b0, '{OP_READING, -8'sd5},  '0, '0, 1'b1, '{12'd2000, 12'd1995, 1'b0}},
    // large deviation takes 1.5 * min off both wheels
    '{1'b0, '{OP_READING, 8'sd14},  '0, '0, 1'b1, '{12'd1236, 12'd1250, 1'b0}},
    '{1'b0, '{OP_READING, -8'sd16}, '0, '0, 1'b1, '{12'd1250, 12'd1234, 1'b0}},
    '{1'b0, '{OP_READING, 8'sd16},  '0, '0, 1'b1, '{12'd1234, 12'd1250, 1'b0}},
    // tick while on the line, then losing the line below the timeout
    '{1'b0, '{OP_TICK, 8'sh55},     '0, '0, 1'b0, '0},
    '{1'b0, '{OP_READING, 8'sd127}, '0, '0, 1'b0, '0},
    '{1'b0, '{OP_TICK, -8'sd128},   '0, '0, 1'b0, '0},
    '{1'b0, '{OP_READING, -8'sd128},'0, '0, 1'b0, '0},
    '{1'b0, '{OP_READING, 8'sd17},  '0, '0, 1'b0, '0},
    '{1'b0, '{OP_READING, -8'sd17}, '0, '0, 1'b0, '0},
    // zero timeout: the counter is already past it
    '{1'b1, '0, CFG_TIMEOUT, 16'd0, 1'b0, '0},
    '{1'b0, '{OP_READING, 8'sd17},  '0, '0, 1'b1, '{12'd0, 12'd0, 1'b1}},
    '{1'b0, '{OP_TICK, 8'sh2A},     '0, '0, 1'b0, '0},
    '{1'b0, '{OP_READING, -8'sd128},'0, '0, 1'b1, '{12'd0, 12'd0, 1'b1}},
    // back on the line at the smallest magnitudes
    '{1'b0, '{OP_READING, 8'sd1},   '0, '0, 1'b1, '{12'd1999, 12'd2000, 1'b0}},
    '{1'b0, '{OP_READING, -8'sd1},  '0, '0, 1'b1, '{12'd2000, 12'd1999, 1'b0}},
    // wide writes keep only the speed width; slowdown drives both wheels under zero
    '{1'b1, '0, CFG_MAX_SPEED, 16'hFFFF, 1'b0, '0},
    '{1'b1, '0, CFG_MIN_SPEED, 16'hFFFF, 1'b0, '0},
    '{1'b0, '{OP_READING, 8'sd14},  '0, '0, 1'b1, '{12'd0, 12'd0, 1'b0}},
    // full gains, no slowdown, walk through the integral and derivative clears
    '{1'b1, '0, CFG_GAIN_P, 16'hFFFF, 1'b0, '0},
    '{1'b1, '0, CFG_GAIN_I, 16'hFFFF, 1'b0, '0},
    '{1'b1, '0, CFG_GAIN_D, 16'hFFFF, 1'b0, '0},
    '{1'b1, '0, CFG_MIN_SPEED, 16'd0, 1'b0, '0},
    '{1'b0, '{OP_READING, -8'sd16}, '0, '0, 1'b0, '0},
    '{1'b0, '{OP_READING, 8'sd7},   '0, '0, 1'b0, '0},
    '{1'b0, '{OP_READING, 8'sd6},   '0, '0, 1'b0, '0},
    '{1'b0, '{OP_READING, -8'sd2},  '0, '0, 1'b0, '0},
    '{1'b0, '{OP_READING, 8'sd1},   '0, '0, 1'b0, '0},
    // slowdown tiers around the speed thresholds, odd min for the half step
    '{1'b1, '0, CFG_MAX_SPEED, 16'd1499, 1'b0, '0},
    '{1'b1, '0, CFG_MIN_SPEED, 16'd3, 1'b0, '0},
    '{1'b1, '0, CFG_GAIN_P, 16'd256, 1'b0, '0},
    '{1'b1, '0, CFG_GAIN_I, 16'd0, 1'b0, '0},
    '{1'b1, '0, CFG_GAIN_D, 16'd0, 1'b0, '0},
    '{1'b0, '{OP_READING, -8'sd15}, '0, '0, 1'b1, '{12'd1496, 12'd1481, 1'b0}},
    '{1'b1, '0, CFG_MAX_SPEED, 16'd1500, 1'b0, '0},
    '{1'b0, '{OP_READING, 8'sd15},  '0, '0, 1'b1, '{12'd1480, 12'd1495, 1'b0}},
    '{1'b1, '0, CFG_MAX_SPEED, 16'd999, 1'b0, '0},
    '{1'b0, '{OP_READING, -8'sd14}, '0, '0, 1'b1, '{12'd999, 12'd985, 1'b0}}
  };

  // block ports, inputs all driven from time zero
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  lfpd_in_t                in_item_i   = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  lfpd_out_t               out_item_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DAT_BITS-1:0] cfg_data_i  = '0;

  // predictor copy of the registers
  longint max_spd, min_spd, line_timeout, kp, ki, kd;
  // predictor copy of the pid and line-lost state
  longint      integ_acc;
  longint      last_mag;
  bit          off_line;
  logic [31:0] off_ms;

  lfpd_out_t speeds_due[$];     // wheel speeds still owed by the block, oldest first
  pin_t      pinned_speeds[$];  // hand-typed results, one entry per item sent
  int        mismatches   = 0;
  int        stuck_cycles = 0;
  int        ready_hold   = 0;
  bit        idling       = 1'b1;

  line_follow_pid_drive_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  task automatic reset_model();
    max_spd      = MAX_SPEED_RST;
    min_spd      = MIN_SPEED_RST;
    line_timeout = TIMEOUT_RST;
    kp           = GAIN_P_RST;
    ki           = GAIN_I_RST;
    kd           = GAIN_D_RST;
    integ_acc    = 0;
    last_mag     = 0;
    off_line     = 1'b0;
    off_ms       = '0;
  endtask

  // twice the exact speed in, clamped to 0..max and truncated
  function automatic logic [SPEED_BITS-1:0] clamp_drive(longint twice, longint top);
    if (twice <= 0) return '0;
    if (twice >= 2 * top) return top[SPEED_BITS-1:0];
    return SPEED_BITS'(twice / 2);
  endfunction

  // advance the predictor by one item; returns 1 when a result is due
  function automatic bit predict_drive(input lfpd_in_t it, output lfpd_out_t res);
    longint dev, mag, slope, pid_sum, cut, left2, right2, slow2;
    res = '0;
    if (it.operation == OP_TICK) begin
      // the lost-line clock only runs while the line is lost, and saturates
      if (off_line && off_ms != '1) off_ms = off_ms + 1;
      return 1'b0;
    end
    dev = longint'($signed(it.deviation));
    mag = (dev < 0) ? -dev : dev;
    if (mag >= LINE_LIMIT) begin
      if (!off_line) begin
        off_line = 1'b1;
        off_ms   = '0;
      end
      // pid state is frozen while off the line
      if (off_ms > line_timeout) begin
        res.line_lost_stop = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    off_line  = 1'b0;
    off_ms    = '0;
    integ_acc = (integ_acc + mag > INTEG_MAX) ? INTEG_MAX : integ_acc + mag;
    slope     = mag - last_mag;
    if (mag <= INTEGRAL_CLEAR) begin
      integ_acc = 0;
      if (mag <= DERIV_CLEAR) slope = 0;
    end
    pid_sum  = kp * mag + ki * integ_acc + kd * slope;
    last_mag = mag;
    cut      = ((pid_sum < 0) ? -pid_sum : pid_sum) >>> 8;
    // work in half units so the 1.5 * min slowdown stays exact
    left2  = 2 * max_spd;
    right2 = left2;
    if (dev < 0) right2 -= 2 * cut;
    else if (dev > 0) left2 -= 2 * cut;
    if (mag >= SLOW_LIMIT) begin
      slow2 = 0;
      if (max_spd >= HIGH_MAX) slow2 = 3 * min_spd;
      else if (max_spd >= MID_MAX) slow2 = 2 * min_spd;
      left2  -= slow2;
      right2 -= slow2;
    end
    res.left_speed  = clamp_drive(left2, max_spd);
    res.right_speed = clamp_drive(right2, max_spd);
    return 1'b1;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // monitor: output check first, so a result never meets an expectation pushed
  // at the same edge
  always @(posedge clk_i) begin
    lfpd_out_t got, want, calc;
    pin_t      pin;
    bit        makes;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = out_item_o;
        if (speeds_due.size() == 0) begin
          note_failure($sformatf("result with nothing owed: left %0d right %0d stop %0b",
                                 got.left_speed, got.right_speed, got.line_lost_stop));
        end else begin
          want = speeds_due.pop_front();
          if (got.left_speed != want.left_speed)
            note_failure($sformatf("left_speed expected %0d, got %0d",
                                   want.left_speed, got.left_speed));
          if (got.right_speed != want.right_speed)
            note_failure($sformatf("right_speed expected %0d, got %0d",
                                   want.right_speed, got.right_speed));
          if (got.line_lost_stop != want.line_lost_stop)
            note_failure($sformatf("line_lost_stop expected %0b, got %0b",
                                   want.line_lost_stop, got.line_lost_stop));
        end
      end
      if (in_valid_i && in_ready_o) begin
        pin   = pinned_speeds.pop_front();
        makes = predict_drive(in_item_i, calc);
        // a typed-in result replaces the predicted one for its row
        if (pin.on) speeds_due.push_back(pin.res);
        else if (makes) speeds_due.push_back(calc);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MAX_SPEED: max_spd      = cfg_data_i[SPEED_BITS-1:0];
          CFG_MIN_SPEED: min_spd      = cfg_data_i[SPEED_BITS-1:0];
          CFG_TIMEOUT:   line_timeout = cfg_data_i;
          CFG_GAIN_P:    kp           = cfg_data_i;
          CFG_GAIN_I:    ki           = cfg_data_i;
          CFG_GAIN_D:    kd           = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // result side back-pressure in bursts, started at random only while idling is set
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold  <= ready_hold - 1;
      out_ready_i <= (ready_hold == 1);
    end else if (idling && $urandom_range(0, 5) == 0) begin
      ready_hold  <= $urandom_range(1, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // offer one item and hold it until taken; valid stays high on return so a
  // following call can swap the payload in the same step
  task automatic send_item(input lfpd_in_t it, input bit pinned, input lfpd_out_t want);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    pinned_speeds.push_back('{pinned, want});
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending, let every owed result drain, then let silent items flush
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (speeds_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [CFG_IDX_BITS-1:0] index,
                             input logic [CFG_DAT_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_DAT_BITS-1:0] draw_setting(lfpd_cfg_e which, int style);
    if (style == STYLE_ONES) return '1;
    if (style == STYLE_ZEROS) return '0;
    case (which)
      CFG_MAX_SPEED:
        // land on both sides of each slowdown threshold
        case ($urandom_range(0, 6))
          0:       return 16'd999;
          1:       return 16'd1000;
          2:       return 16'd1499;
          3:       return 16'd1500;
          4:       return 16'd4095;
          default: return CFG_DAT_BITS'($urandom);
        endcase
      CFG_MIN_SPEED:
        return ($urandom_range(0, 1) != 0) ? CFG_DAT_BITS'($urandom_range(0, 1023))
                                           : CFG_DAT_BITS'($urandom);
      CFG_TIMEOUT:
        // short timeouts so lost-line spells run into the stop
        return ($urandom_range(0, 7) == 0) ? '1 : CFG_DAT_BITS'($urandom_range(0, 12));
      default:
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return 16'd256;
          2:       return CFG_DAT_BITS'($urandom);
          default: return CFG_DAT_BITS'($urandom_range(0, 1023));
        endcase
    endcase
  endfunction

  task automatic retune(input int style);
    lfpd_cfg_e which;
    which = which.first();
    repeat (which.num()) begin
      program_reg(which, draw_setting(which, style));
      which = which.next();
    end
  endtask

  function automatic lfpd_in_t draw_item(pick_e pick);
    lfpd_in_t it;
    it.operation = OP_READING;
    case (pick)
      PICK_ON_LINE:  it.deviation = DEV_BITS'($urandom_range(0, 32) - 16);
      PICK_OFF_LINE: it.deviation = ($urandom_range(0, 1) != 0)
                                    ? DEV_BITS'($urandom_range(17, 127))
                                    : DEV_BITS'(256 - $urandom_range(17, 128));
      PICK_TICK: begin
        it.operation = OP_TICK;
        it.deviation = DEV_BITS'($urandom);  // ignored by the block
      end
      default: it = IN_BITS'($urandom);
    endcase
    return it;
  endfunction

  // mostly on-line runs and lost-line spells, with a little raw noise
  task automatic run_phase(input int quota);
    int    sent;
    int    spell;
    pick_e pick;
    sent = 0;
    while (sent < quota) begin
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          spell = $urandom_range(1, 12);
          repeat (spell) send_item(draw_item(PICK_ON_LINE), 1'b0, '0);
          sent += spell;
        end
        3, 4: begin
          // lose the line, then let the clock run with the odd lost reading
          spell = $urandom_range(1, 30);
          send_item(draw_item(PICK_OFF_LINE), 1'b0, '0);
          repeat (spell) begin
            pick = ($urandom_range(0, 4) < 3) ? PICK_TICK : PICK_OFF_LINE;
            send_item(draw_item(pick), 1'b0, '0);
          end
          sent += spell + 1;
        end
        default: begin
          send_item(draw_item(PICK_NOISE), 1'b0, '0);
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    lfpd_in_t soak_item;
    reset_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed walk: extremes, both operations, clears, thresholds, timeout
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].is_cfg) begin
        wait_idle();
        program_reg(PLAN[i].reg_index, PLAN[i].reg_data);
      end else begin
        send_item(PLAN[i].item, PLAN[i].pinned, PLAN[i].pinned_res);
      end
    end

    // integral soak: unit integral gain only, so the cut tracks the
    // accumulator and its growth shows up directly in the speeds
    wait_idle();
    program_reg(CFG_MAX_SPEED, 16'd4095);
    program_reg(CFG_MIN_SPEED, 16'd0);
    program_reg(CFG_GAIN_P, 16'd0);
    program_reg(CFG_GAIN_I, 16'd256);
    program_reg(CFG_GAIN_D, 16'd0);
    soak_item.operation = OP_READING;
    repeat (SOAK_ITEMS) begin
      soak_item.deviation = ($urandom_range(0, 1) != 0) ? DEV_BITS'(16) : DEV_BITS'(-16);
      send_item(soak_item, 1'b0, '0);
    end

    // random phases; each one starts from a fully drained block, the first
    // two with all ones and all zeros, and the last with no idling at all
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      idling = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      retune((p == 0) ? STYLE_ONES : (p == 1) ? STYLE_ZEROS : STYLE_RANDOM);
      run_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (speeds_due.size() != 0)
      note_failure($sformatf("%0d results never came", speeds_due.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
